[hw/rtl/automaton_pattern_match_trace_core_macros.svh]
// Assertion macros shared by the pattern-match trace RTL.
`ifndef AUTOMATON_PATTERN_MATCH_TRACE_CORE_MACROS_SVH
`define AUTOMATON_PATTERN_MATCH_TRACE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define APMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define APMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/apmt_pkg.sv]
// Shared types and constants for the pattern-match trace core.
package apmt_pkg;

  localparam int MAX_PATTERN_DEF = 256;
  localparam int LEN_W   = 9;
  localparam int BYTE_W  = 8;
  localparam int TRACE_W = 32;
  localparam int OP_W    = 2;

  localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
  localparam logic [OP_W-1:0] OP_TEXT    = 2'd1;
  localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 9'd1;

  // Per-cycle commands broadcast to every cell of the chain.
  typedef struct packed {
    logic clear;         // empty the prefix-match bit
    logic step;          // advance the prefix-match bit by one symbol
    logic load_replay;   // copy the pattern byte into the replay stage
    logic shift_replay;  // move the replay byte one cell toward cell 0
  } cell_ctl_t;

endpackage

[hw/rtl/apmt_cell.sv]
// One automaton cell: a pattern byte, its prefix-match bit and a replay stage.
module apmt_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  apmt_pkg::cell_ctl_t            ctl,
  input  logic                           load_en,
  input  logic [apmt_pkg::BYTE_W-1:0]    load_byte,
  input  logic [apmt_pkg::BYTE_W-1:0]    symbol,
  input  logic                           prev_match,
  input  logic                           active,
  input  logic [apmt_pkg::BYTE_W-1:0]    replay_in,
  output logic                           match,
  output logic [apmt_pkg::BYTE_W-1:0]    replay_out
);

  logic [apmt_pkg::BYTE_W-1:0] pat_byte;
  logic [apmt_pkg::BYTE_W-1:0] replay_byte;

  // Hold the pattern byte written by a load transaction
  always_ff @(posedge clk) begin
    if (load_en) begin
      pat_byte <= load_byte;
    end
  end

  // Load or shift the replay line
  always_ff @(posedge clk) begin
    if (ctl.load_replay) begin
      replay_byte <= pat_byte;
    end else if (ctl.shift_replay) begin
      replay_byte <= replay_in;
    end
  end

  // Prefix of length j+1 ends here if prefix j ended one symbol earlier
  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (ctl.clear) begin
      match <= 1'b0;
    end else if (ctl.step) begin
      match <= prev_match && active && (pat_byte == symbol);
    end
  end

  assign replay_out = replay_byte;

endmodule

[hw/rtl/apmt_prio_enc.sv]
// Priority encoder: one plus the index of the highest set prefix-match bit.
module apmt_prio_enc #(
  parameter int MAX_PATTERN = apmt_pkg::MAX_PATTERN_DEF
) (
  input  logic [MAX_PATTERN-1:0]             match_vec,
  output logic [$clog2(MAX_PATTERN+1)-1:0]   state
);

  localparam int SW = $clog2(MAX_PATTERN + 1);

  // Highest set bit wins
  always_comb begin
    state = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (match_vec[j]) begin
        state = SW'(j + 1);
      end
    end
  end

endmodule

[hw/rtl/automaton_pattern_match_trace_core.sv]
// Top level of the string-matching automaton with running state trace.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser[1:0] op; tdata[7:0] index, [15:8] byte
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[31:0] trace_value
//  cfg       in   cfg_we                       cfg_wdata[8:0] pattern_length
//
// A text byte steps every cell of the chain together; a second stage encodes the
// state and updates the trace, so text bytes stream at one per cycle unless a replay
// runs or a stalled result holds a pending state. A pattern load or length write marks
// the chain stale; the next text byte then waits while the chain replays its pattern prefix.
// Reset clears state, trace and match bits; pattern bytes stay undefined until loaded.
// A stalled result blocks input only when a new state is also pending.
module automaton_pattern_match_trace_core #(
  parameter int MAX_PATTERN = apmt_pkg::MAX_PATTERN_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [15:0]                        s_axis_tdata,  // [7:0] pattern_index, [15:8] byte_value
  input  logic [apmt_pkg::OP_W-1:0]          s_axis_tuser,  // [1:0] op
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [apmt_pkg::TRACE_W-1:0]       m_axis_tdata,  // [31:0] trace_value
  input  logic                               cfg_we,
  input  logic [apmt_pkg::LEN_W-1:0]         cfg_wdata      // [8:0] pattern_length
);

`include "automaton_pattern_match_trace_core_macros.svh"

  localparam int SW = $clog2(MAX_PATTERN + 1);

  logic [apmt_pkg::LEN_W-1:0]   len_raw;
  logic [apmt_pkg::LEN_W-1:0]   len_eff;
  logic [SW-1:0]                state;
  logic [SW-1:0]                state_cap;
  logic [SW-1:0]                enc_state;
  logic [SW-1:0]                replay_cnt;
  logic [apmt_pkg::TRACE_W-1:0] trace;
  logic [apmt_pkg::TRACE_W-1:0] trace_next;
  logic                         dirty;
  logic                         rec;
  logic                         rec_start;
  logic                         rec_step;
  logic                         pend;
  logic                         out_blocked;
  logic                         fire_b;
  logic                         acc;
  logic                         load_acc;
  logic                         text_acc;
  logic                         restart_acc;
  logic                         head_is_text;
  logic [apmt_pkg::BYTE_W-1:0]  symbol;
  apmt_pkg::cell_ctl_t          ctl;

  logic [MAX_PATTERN-1:0]       match_vec;
  logic [apmt_pkg::BYTE_W-1:0]  replay [MAX_PATTERN+1];

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      len_raw <= apmt_pkg::LEN_RESET;
    end else if (cfg_we) begin
      len_raw <= cfg_wdata;
    end
  end

  // Clamp the length to 1..MAX_PATTERN
  always_comb begin
    if (len_raw == '0) begin
      len_eff = apmt_pkg::LEN_W'(1);
    end else if (32'(len_raw) > 32'(MAX_PATTERN)) begin
      len_eff = apmt_pkg::LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_raw;
    end
  end

  assign state_cap = (32'(state) > 32'(len_eff)) ? SW'(len_eff) : state;

  // Decode the transaction kind
  assign head_is_text = (s_axis_tuser == apmt_pkg::OP_TEXT);
  assign out_blocked  = m_axis_tvalid && !m_axis_tready;
  assign fire_b       = pend && !out_blocked;
  assign s_axis_tready = !rec && !(pend && out_blocked) && !(dirty && head_is_text);
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    load_acc    = 1'b0;
    text_acc    = 1'b0;
    restart_acc = 1'b0;
    case (s_axis_tuser)
      apmt_pkg::OP_LOAD:    load_acc    = acc;
      apmt_pkg::OP_TEXT:    text_acc    = acc;
      apmt_pkg::OP_RESTART: restart_acc = acc;
      default:              ;
    endcase
  end

  // Start a replay when a text byte waits on a stale chain
  assign rec_start = dirty && !rec && !pend && s_axis_tvalid && head_is_text && !cfg_we;
  assign rec_step  = rec && (replay_cnt != '0);

  // Chain commands
  always_comb begin
    ctl.clear        = restart_acc || rec_start;
    ctl.step         = text_acc || rec_step;
    ctl.load_replay  = rec_start;
    ctl.shift_replay = rec_step;
  end

  assign symbol = rec ? replay[0] : s_axis_tdata[15:8];
  assign replay[MAX_PATTERN] = '0;

  // Chain of cells
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic prev_match;
    if (j == 0) begin : g_first
      assign prev_match = 1'b1;
    end else begin : g_rest
      assign prev_match = match_vec[j-1];
    end

    apmt_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .load_en    (load_acc && (32'(s_axis_tdata[7:0]) == 32'(j))),
      .load_byte  (s_axis_tdata[15:8]),
      .symbol     (symbol),
      .prev_match (prev_match),
      .active     (32'(len_eff) > 32'(j)),
      .replay_in  (replay[j+1]),
      .match      (match_vec[j]),
      .replay_out (replay[j])
    );
  end

  apmt_prio_enc #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_enc (
    .match_vec (match_vec),
    .state     (enc_state)
  );

  // Replay sequencer and stale flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rec        <= 1'b0;
      dirty      <= 1'b0;
      replay_cnt <= '0;
    end else begin
      if (rec_start) begin
        rec        <= 1'b1;
        replay_cnt <= state_cap;
      end else if (rec) begin
        if (replay_cnt != '0) begin
          replay_cnt <= replay_cnt - SW'(1);
        end else begin
          rec   <= 1'b0;
          dirty <= 1'b0;
        end
      end
      if (load_acc) begin
        dirty <= 1'b1;
      end
      if (restart_acc) begin
        dirty <= 1'b0;
      end
      if (cfg_we) begin
        dirty <= 1'b1;
        rec   <= 1'b0;
      end
    end
  end

  assign trace_next = {trace[apmt_pkg::TRACE_W-2:0], 1'b0} ^ apmt_pkg::TRACE_W'(enc_state);

  // Second stage: encode state, advance trace, drop restarts in
  always_ff @(posedge clk) begin
    if (rst) begin
      pend  <= 1'b0;
      state <= '0;
      trace <= '0;
    end else begin
      if (text_acc) begin
        pend <= 1'b1;
      end else if (fire_b) begin
        pend <= 1'b0;
      end
      if (rec_start) begin
        state <= state_cap;
      end else if (fire_b) begin
        state <= enc_state;
        trace <= trace_next;
      end
      if (restart_acc) begin
        state <= '0;
        trace <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire_b && (32'(enc_state) == 32'(len_eff))) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire_b && (32'(enc_state) == 32'(len_eff))) begin
      m_axis_tdata <= trace_next;
    end
  end

  `APMT_ASSERT_NOW(a_text_on_clean_chain, text_acc, !dirty && !rec, "text byte accepted on stale chain")
  `APMT_ASSERT_NEXT(a_replay_starts_empty, rec_start, rec && (match_vec == '0), "replay did not start empty")
  `APMT_ASSERT_NOW(a_match_within_len, !dirty && !rec, (match_vec >> len_eff) == '0, "match bit beyond length")
  `APMT_ASSERT_NOW(a_pending_stall, pend && out_blocked, !s_axis_tready, "input taken while stage two stalls")

endmodule

[sim/testbench.sv]
// Self-checking testbench for the string-matching automaton with running state trace.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import apmt_pkg::*;

  localparam int SETTLE_CYCLES = 264;   // pipeline plus the longest prefix replay
  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off to back up the block
  localparam int STALL_LIMIT   = 4000;  // cycles without a transaction before giving up
  localparam int RANDOM_ITEMS  = 450;
  localparam int RANDOM_TRACES = 48;
  localparam int MAX_REPORTS   = 40;
  localparam int STORE_DEPTH   = MAX_PATTERN_DEF;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    ROW_PREDICT,  // expectation comes from the matcher model below
    ROW_QUIET,    // no trace may come out
    ROW_TRACE,    // trace value typed into the row
    ROW_LENGTH    // write arg into the length register
  } row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] idx;
    logic [BYTE_W-1:0] val;
    logic [31:0]       arg;
  } stim_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [15:0]          s_axis_tdata = '0;   // [7:0] pattern_index, [15:8] byte_value
  logic [OP_W-1:0]      s_axis_tuser = '0;   // [1:0] op
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [TRACE_W-1:0]   m_axis_tdata;        // [31:0] trace_value
  logic                 cfg_we = 1'b0;
  logic [LEN_W-1:0]     cfg_wdata = '0;      // [8:0] pattern_length

  // Matcher model state
  logic [BYTE_W-1:0]    pat_mem [STORE_DEPTH];
  logic [LEN_W-1:0]     len_reg = LEN_RESET;
  logic [LEN_W-1:0]     match_q = '0;
  logic [TRACE_W-1:0]   trace_acc = '0;

  logic [TRACE_W-1:0]   trace_q [$];
  stim_row_t            directed_rows [$];

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int errors = 0;
  int results_seen = 0;
  int traces_due = 0;
  int items_sent = 0;
  int texts_sent = 0;
  int length_writes = 0;
  int holds_done = 0;

  automaton_pattern_match_trace_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Length in force: zero acts as one, anything past the store acts as the store size.
  function automatic int unsigned active_length();
    int unsigned len;
    len = len_reg;
    if (len == 0) len = 1;
    if (len > STORE_DEPTH) len = STORE_DEPTH;
    return len;
  endfunction

  // Longest prefix k that ends the string pattern[0..s-1] followed by x.
  function automatic int unsigned next_match(input int unsigned s, input int unsigned len,
                                             input logic [BYTE_W-1:0] x);
    int k;
    int j;
    bit agree;
    for (k = (s < len) ? s + 1 : len; k > 0; k--) begin
      if (pat_mem[k-1] == x) begin
        agree = 1'b1;
        for (j = 0; j < k - 1; j++)
          if (pat_mem[j] != pat_mem[s - k + 1 + j]) agree = 1'b0;
        if (agree) return k;
      end
    end
    return 0;
  endfunction

  // Advance the model by one accepted input transaction.
  function automatic void predict_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] idx,
                                       input logic [BYTE_W-1:0] val, output bit fires,
                                       output logic [TRACE_W-1:0] trace);
    int unsigned len;
    int unsigned s;
    fires = 1'b0;
    trace = '0;
    case (op)
      OP_LOAD: pat_mem[idx] = val;
      OP_RESTART: begin
        match_q = '0;
        trace_acc = '0;
      end
      OP_TEXT: begin
        len = active_length();
        s = match_q;
        if (s > len) s = len;
        match_q = LEN_W'(next_match(s, len, val));
        trace_acc = (trace_acc << 1) ^ match_q;
        if (match_q == len) begin
          fires = 1'b1;
          trace = trace_acc;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_trace(input logic [TRACE_W-1:0] got);
    logic [TRACE_W-1:0] want;
    results_seen++;
    if (trace_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: trace mismatch: expected none, actual %h", $time, got);
    end else begin
      want = trace_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: trace mismatch: expected %h, actual %h", $time, want, got);
      end
    end
  endfunction

  task automatic add_row(input row_kind_e kind, input logic [OP_W-1:0] op,
                         input logic [BYTE_W-1:0] idx, input logic [BYTE_W-1:0] val,
                         input logic [31:0] arg);
    stim_row_t r;
    r.kind = kind;
    r.op   = op;
    r.idx  = idx;
    r.val  = val;
    r.arg  = arg;
    directed_rows.push_back(r);
  endtask

  // Offer one input transaction after a random gap and record what it must produce.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] idx,
                           input logic [BYTE_W-1:0] val, input row_kind_e kind,
                           input logic [31:0] typed);
    int gap;
    bit fires;
    logic [TRACE_W-1:0] trace;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      @(negedge clk);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = op;
    s_axis_tdata  = {val, idx};
    do @(posedge clk); while (!s_axis_tready);
    predict_item(op, idx, val, fires, trace);
    items_sent++;
    if (op == OP_TEXT) texts_sent++;
    case (kind)
      ROW_TRACE: begin
        trace_q.push_back(typed);
        traces_due++;
      end
      ROW_PREDICT: if (fires) begin
        trace_q.push_back(trace);
        traces_due++;
      end
      default: ;
    endcase
  endtask

  task automatic send_text(input logic [BYTE_W-1:0] val);
    send_item(OP_TEXT, BYTE_W'($urandom_range(0, 255)), val, ROW_PREDICT, '0);
  endtask

  // Drain the block, let it settle, then write the length register.
  task automatic write_length(input logic [LEN_W-1:0] value);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (trace_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    len_reg = value;
    length_writes++;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Receiver: random stall per result, one long hold-off on request.
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall = HOLD_CYCLES;
        holds_done++;
      end else begin
        stall = calm ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        @(negedge clk);
        m_axis_tready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      m_axis_tready = 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      check_trace(m_axis_tdata);
    end
  end

  // Watchdog: end the run when no transaction moves for too long.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle = 0;
      else idle++;
      if (idle >= STALL_LIMIT) begin
        $display("%0t: watchdog: no transaction for %0d cycles, %0d traces outstanding",
                 $time, idle, trace_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t row;
    logic [LEN_W-1:0] len_pick;
    logic [BYTE_W-1:0] fill_byte;
    logic [BYTE_W-1:0] alpha [3];
    int unsigned le;
    int alpha_n;
    int pick;
    int lead;
    int n_items;
    int phase;
    int rand_items;
    int rand_traces0;
    int i;
    int j;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed rows: reset length, single-byte matches, restart, unused op,
    // length zero, two-byte pattern and a state left above a shorter length.
    add_row(ROW_QUIET,   OP_LOAD,    8'h00, 8'h5A, 0);
    add_row(ROW_TRACE,   OP_TEXT,    8'h00, 8'h5A, 1);
    add_row(ROW_TRACE,   OP_TEXT,    8'hFF, 8'h5A, 3);
    add_row(ROW_QUIET,   OP_TEXT,    8'h00, 8'h00, 0);
    add_row(ROW_TRACE,   OP_TEXT,    8'h00, 8'h5A, 13);
    add_row(ROW_QUIET,   OP_RESTART, 8'hFF, 8'hFF, 0);
    add_row(ROW_TRACE,   OP_TEXT,    8'h00, 8'h5A, 1);
    add_row(ROW_QUIET,   OP_UNUSED,  8'hFF, 8'h5A, 0);
    add_row(ROW_QUIET,   OP_TEXT,    8'h00, 8'hFF, 0);
    add_row(ROW_QUIET,   OP_LOAD,    8'hFF, 8'hFF, 0);
    add_row(ROW_QUIET,   OP_LOAD,    8'h00, 8'hFF, 0);
    add_row(ROW_TRACE,   OP_TEXT,    8'h00, 8'hFF, 5);
    add_row(ROW_LENGTH,  OP_LOAD,    8'h00, 8'h00, 0);
    add_row(ROW_TRACE,   OP_TEXT,    8'h00, 8'hFF, 11);
    add_row(ROW_QUIET,   OP_LOAD,    8'h01, 8'h00, 0);
    add_row(ROW_LENGTH,  OP_LOAD,    8'h00, 8'h00, 2);
    add_row(ROW_QUIET,   OP_RESTART, 8'h00, 8'h00, 0);
    add_row(ROW_QUIET,   OP_TEXT,    8'h00, 8'hFF, 0);
    add_row(ROW_TRACE,   OP_TEXT,    8'h00, 8'h00, 0);
    add_row(ROW_LENGTH,  OP_LOAD,    8'h00, 8'h00, 1);
    add_row(ROW_TRACE,   OP_TEXT,    8'h00, 8'hFF, 1);
    add_row(ROW_PREDICT, OP_TEXT,    8'h5A, 8'h00, 0);
    add_row(ROW_PREDICT, OP_TEXT,    8'hA5, 8'hFF, 0);
    add_row(ROW_PREDICT, OP_TEXT,    8'h3C, 8'hFF, 0);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_LENGTH) write_length(row.arg[LEN_W-1:0]);
      else send_item(row.op, row.idx, row.val, row.kind, row.arg);
    end

    // Full-size pattern: fill the whole store, then match it end to end.
    fill_byte = BYTE_W'($urandom_range(0, 255));
    write_length(9'd256);
    send_item(OP_RESTART, BYTE_W'($urandom_range(0, 255)), fill_byte, ROW_PREDICT, '0);
    for (i = STORE_DEPTH - 1; i >= 0; i--)
      send_item(OP_LOAD, BYTE_W'(i), fill_byte, ROW_PREDICT, '0);
    for (i = 0; i < STORE_DEPTH + 2; i++) send_text(fill_byte);

    // Oversized lengths act as the store size; keep the stream going.
    write_length(9'd511);
    for (i = 0; i < 4; i++) send_text(fill_byte);
    write_length(9'd257);
    for (i = 0; i < 3; i++) send_text(fill_byte);

    // Shrink the length under a full-size state.
    write_length(9'd3);
    for (i = 0; i < 3; i++) send_text(fill_byte);
    send_text(fill_byte ^ 8'h01);

    // Random phases: new length, fresh short pattern, then a mostly matching stream.
    phase = 0;
    rand_items = 0;
    rand_traces0 = traces_due;
    while (rand_items < RANDOM_ITEMS || traces_due - rand_traces0 < RANDOM_TRACES) begin
      calm = (phase == 1) || ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (phase == 1) len_pick = 9'd1;
      else if (pick < 60) len_pick = LEN_W'($urandom_range(1, 6));
      else if (pick < 85) len_pick = LEN_W'($urandom_range(7, 20));
      else if (pick < 95) len_pick = LEN_W'($urandom_range(21, 64));
      else if (pick < 97) len_pick = '0;
      else len_pick = LEN_W'($urandom_range(257, 511));
      write_length(len_pick);
      le = active_length();

      if ($urandom_range(0, 1) == 1) begin
        send_item(OP_RESTART, BYTE_W'($urandom_range(0, 255)),
                  BYTE_W'($urandom_range(0, 255)), ROW_PREDICT, '0);
        rand_items++;
      end

      alpha_n = $urandom_range(2, 3);
      foreach (alpha[i]) alpha[i] = BYTE_W'($urandom_range(0, 255));
      if (le <= 64) begin
        for (i = 0; i < le; i++) begin
          send_item(OP_LOAD, BYTE_W'(i), alpha[$urandom_range(0, alpha_n - 1)],
                    ROW_PREDICT, '0);
          rand_items++;
        end
      end

      if (phase == 1) begin
        // Back-to-back matches against a receiver that holds off.
        hold_req = 1'b1;
        for (i = 0; i < 40; i++) send_text(pat_mem[0]);
        rand_items += 40;
      end else begin
        n_items = $urandom_range(25, 60);
        for (i = 0; i < n_items; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 45 && le <= 64) begin
            lead = $urandom_range(0, 2);
            for (j = 0; j < lead; j++) send_text(alpha[$urandom_range(0, alpha_n - 1)]);
            for (j = 0; j < le; j++) send_text(pat_mem[j]);
            rand_items += lead + le;
          end else if (pick < 75) begin
            send_text(alpha[$urandom_range(0, alpha_n - 1)]);
            rand_items++;
          end else if (pick < 85) begin
            send_text(BYTE_W'($urandom_range(0, 255)));
            rand_items++;
          end else if (pick < 90) begin
            send_item(OP_RESTART, BYTE_W'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)), ROW_PREDICT, '0);
            rand_items++;
          end else if (pick < 94) begin
            send_item(OP_UNUSED, BYTE_W'($urandom_range(0, 255)),
                      BYTE_W'($urandom_range(0, 255)), ROW_PREDICT, '0);
          end else begin
            fill_byte = ($urandom_range(0, 1) == 1) ? alpha[$urandom_range(0, alpha_n - 1)]
                                                    : BYTE_W'($urandom_range(0, 255));
            send_item(OP_LOAD, BYTE_W'($urandom_range(0, 255)), fill_byte, ROW_PREDICT, '0);
            rand_items++;
          end
        end
      end
      phase++;
    end

    // Drain and let the pipeline settle.
    calm = 1'b0;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (trace_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d input transactions (%0d text bytes) over %0d length settings",
             items_sent, texts_sent, length_writes);
    $display("checked %0d trace results, %0d long receiver holds, %0d mismatches",
             results_seen, holds_done, errors);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
